[hdl/mi3_pkg.sv]
package mi3_pkg;

  localparam int EL_W      = 16;
  localparam int PROD_W    = 32;
  localparam int COF_W     = 33;
  localparam int DP_W      = 49;
  localparam int DET_W     = 50;
  localparam int FRAC_SH   = 24;
  localparam int NUM_W     = COF_W + FRAC_SH;   // signed numerator
  localparam int NMAG_W    = NUM_W - 1;         // numerator magnitude
  localparam int DMAG_W    = DET_W - 1;         // determinant magnitude
  localparam int Q_W       = 33;                // quotient bits kept
  localparam int CMP_W     = DMAG_W + Q_W;      // trial compare width
  localparam int OUT_W     = 32;
  localparam int N_EL      = 9;
  localparam int FRONT_STG = 5;
  localparam int DIV_STG   = Q_W + 1;
  localparam int PIPE_STG  = FRONT_STG + DIV_STG;

  typedef logic signed [EL_W-1:0]   elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [DP_W-1:0]   dp_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic signed [NUM_W-1:0]  num_t;
  typedef logic [NMAG_W-1:0]        nmag_t;
  typedef logic [DMAG_W-1:0]        dmag_t;
  typedef logic [Q_W-1:0]           quo_t;
  typedef logic [CMP_W-1:0]         cmp_t;

  typedef struct packed {
    logic [OUT_W-1:0] val;
    logic             sat;
    logic             dz;
  } lane_res_t;

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam quo_t POS_LIM = quo_t'(OUT_MAX);
  localparam quo_t NEG_LIM = quo_t'(OUT_MAX) + quo_t'(1);

endpackage

[hdl/matrix_inverse_3x3_top.sv]
// channel | ports                                  | transfer when
// input   | in_valid, in_ready, in_a_r*c*          | in_valid && in_ready
// result  | out_valid, out_ready, out_inv_r*c*,    | out_valid && out_ready
//         | out_singular, out_saturated            |
// One matrix per cycle unless out_ready stalls; 5 product/cofactor/determinant stages,
// 34 divider stages (setup, then one quotient bit each; nine lanes), 1 output register.
// Each stage advances when empty or when the stage after it advances, so bubbles close up.
// rst_n (synchronous) clears all valid bits; data registers are not reset.
module matrix_inverse_3x3_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_a_r0c0,
  input  logic [15:0] in_a_r0c1,
  input  logic [15:0] in_a_r0c2,
  input  logic [15:0] in_a_r1c0,
  input  logic [15:0] in_a_r1c1,
  input  logic [15:0] in_a_r1c2,
  input  logic [15:0] in_a_r2c0,
  input  logic [15:0] in_a_r2c1,
  input  logic [15:0] in_a_r2c2,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_inv_r0c0,
  output logic [31:0] out_inv_r0c1,
  output logic [31:0] out_inv_r0c2,
  output logic [31:0] out_inv_r1c0,
  output logic [31:0] out_inv_r1c1,
  output logic [31:0] out_inv_r1c2,
  output logic [31:0] out_inv_r2c0,
  output logic [31:0] out_inv_r2c1,
  output logic [31:0] out_inv_r2c2,
  output logic        out_singular,
  output logic        out_saturated
);
  import mi3_pkg::*;

  logic [PIPE_STG-1:0] v_r;
  logic [PIPE_STG:0]   en_w;
  logic                out_valid_r;
  elem_t               a_w   [N_EL];
  cof_t                cof_w [N_EL];
  det_t                det_w;
  lane_res_t           res_w [N_EL];
  logic [OUT_W-1:0]    inv_r [N_EL];
  logic                sing_r;
  logic                sat_r;
  logic                sat_any;

  assign en_w[PIPE_STG] = !out_valid_r || out_ready;
  for (genvar i = 0; i < PIPE_STG; i++) begin : g_en
    assign en_w[i] = !v_r[i] || en_w[i+1];
  end
  assign in_ready = en_w[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_w[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < PIPE_STG; i++) begin
        if (en_w[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
      if (en_w[PIPE_STG]) begin
        out_valid_r <= v_r[PIPE_STG-1];
      end
    end
  end

  assign a_w[0] = in_a_r0c0;
  assign a_w[1] = in_a_r0c1;
  assign a_w[2] = in_a_r0c2;
  assign a_w[3] = in_a_r1c0;
  assign a_w[4] = in_a_r1c1;
  assign a_w[5] = in_a_r1c2;
  assign a_w[6] = in_a_r2c0;
  assign a_w[7] = in_a_r2c1;
  assign a_w[8] = in_a_r2c2;

  mi3_front u_front (
    .clk (clk),
    .en  (en_w[FRONT_STG-1:0]),
    .a   (a_w),
    .cof (cof_w),
    .det (det_w)
  );

  for (genvar k = 0; k < N_EL; k++) begin : g_lane
    mi3_div_lane u_lane (
      .clk (clk),
      .en  (en_w[PIPE_STG-1:FRONT_STG]),
      .cof (cof_w[k]),
      .det (det_w),
      .res (res_w[k])
    );
  end

  always_comb begin
    sat_any = 1'b0;
    for (int k = 0; k < N_EL; k++) begin
      sat_any = sat_any | res_w[k].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en_w[PIPE_STG]) begin
      sing_r <= res_w[0].dz;
      sat_r  <= !res_w[0].dz && sat_any;
      for (int k = 0; k < N_EL; k++) begin
        inv_r[k] <= res_w[0].dz ? '0 : res_w[k].val;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_inv_r0c0  = inv_r[0];
  assign out_inv_r0c1  = inv_r[1];
  assign out_inv_r0c2  = inv_r[2];
  assign out_inv_r1c0  = inv_r[3];
  assign out_inv_r1c1  = inv_r[4];
  assign out_inv_r1c2  = inv_r[5];
  assign out_inv_r2c0  = inv_r[6];
  assign out_inv_r2c1  = inv_r[7];
  assign out_inv_r2c2  = inv_r[8];
  assign out_singular  = sing_r;
  assign out_saturated = sat_r;

  a_sing_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> !out_saturated)
    else $error("saturated flag set on singular result");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_inv_r0c0 == '0 && out_inv_r1c1 == '0 &&
      out_inv_r2c2 == '0 && out_inv_r0c2 == '0 && out_inv_r2c0 == '0)
    else $error("singular result carries nonzero entries");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[PIPE_STG-1] && en_w[PIPE_STG] |=> out_valid)
    else $error("last stage item lost on its way to output");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

[hdl/mi3_front.sv]
module mi3_front (
  input  logic                                clk,
  input  logic [mi3_pkg::FRONT_STG-1:0]       en,
  input  mi3_pkg::elem_t                      a [mi3_pkg::N_EL],
  output mi3_pkg::cof_t                       cof [mi3_pkg::N_EL],
  output mi3_pkg::det_t                       det
);
  import mi3_pkg::*;

  elem_t m_r    [N_EL];
  prod_t pa_r   [N_EL];
  prod_t pb_r   [N_EL];
  elem_t row1_r [3];
  elem_t row2_r [3];
  cof_t  cof2_r [N_EL];
  cof_t  cof3_r [N_EL];
  cof_t  cof4_r [N_EL];
  dp_t   dp_r   [3];
  det_t  det_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m_r <= a;
    end
  end

  // adjugate entry (p,q) is the cofactor of element (q,p)
  for (genvar p = 0; p < 3; p++) begin : g_p
    for (genvar q = 0; q < 3; q++) begin : g_q
      localparam int K  = p * 3 + q;
      localparam int Q1 = (q + 1) % 3;
      localparam int Q2 = (q + 2) % 3;
      localparam int P1 = (p + 1) % 3;
      localparam int P2 = (p + 2) % 3;
      always_ff @(posedge clk) begin
        if (en[1]) begin
          pa_r[K] <= m_r[Q1*3+P1] * m_r[Q2*3+P2];
          pb_r[K] <= m_r[Q1*3+P2] * m_r[Q2*3+P1];
        end
        if (en[2]) begin
          cof2_r[K] <= cof_t'(pa_r[K]) - cof_t'(pb_r[K]);
        end
        if (en[3]) begin
          cof3_r[K] <= cof2_r[K];
        end
        if (en[4]) begin
          cof4_r[K] <= cof3_r[K];
        end
      end
    end
  end

  for (genvar d = 0; d < 3; d++) begin : g_row0
    always_ff @(posedge clk) begin
      if (en[1]) begin
        row1_r[d] <= m_r[d];
      end
      if (en[2]) begin
        row2_r[d] <= row1_r[d];
      end
      if (en[3]) begin
        dp_r[d] <= dp_t'(row2_r[d]) * dp_t'(cof2_r[d*3]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      det_r <= det_t'(dp_r[0]) + det_t'(dp_r[1]) + det_t'(dp_r[2]);
    end
  end

  assign cof = cof4_r;
  assign det = det_r;

endmodule

[hdl/mi3_div_lane.sv]
module mi3_div_lane (
  input  logic                          clk,
  input  logic [mi3_pkg::DIV_STG-1:0]   en,
  input  mi3_pkg::cof_t                 cof,
  input  mi3_pkg::det_t                 det,
  output mi3_pkg::lane_res_t            res
);
  import mi3_pkg::*;

  nmag_t rem_r [DIV_STG];
  dmag_t d_r   [DIV_STG];
  quo_t  q_r   [DIV_STG];
  logic  neg_r [DIV_STG];
  logic  ovf_r [DIV_STG];

  num_t  num;
  num_t  num_abs;
  det_t  det_abs;
  quo_t  q_fin;

  assign num     = {cof, {FRAC_SH{1'b0}}};
  assign num_abs = num[NUM_W-1] ? -num : num;
  assign det_abs = det[DET_W-1] ? -det : det;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= num_abs[NMAG_W-1:0];
      d_r[0]   <= det_abs[DMAG_W-1:0];
      q_r[0]   <= '0;
      neg_r[0] <= cof[COF_W-1] ^ det[DET_W-1];
      ovf_r[0] <= cmp_t'(num_abs[NMAG_W-1:0]) >= (cmp_t'(det_abs[DMAG_W-1:0]) << Q_W);
    end
  end

  // one quotient bit per stage, msb first
  for (genvar j = 1; j < DIV_STG; j++) begin : g_stg
    localparam int K = Q_W - j;
    cmp_t  dsh;
    logic  ge;
    nmag_t rem_nxt;
    quo_t  q_nxt;
    always_comb begin
      dsh   = cmp_t'(d_r[j-1]) << K;
      ge    = cmp_t'(rem_r[j-1]) >= dsh;
      rem_nxt = ge ? rem_r[j-1] - dsh[NMAG_W-1:0] : rem_r[j-1];
      q_nxt = q_r[j-1];
      q_nxt[K] = ge;
    end
    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= rem_nxt;
        d_r[j]   <= d_r[j-1];
        q_r[j]   <= q_nxt;
        neg_r[j] <= neg_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  assign q_fin = q_r[DIV_STG-1];

  always_comb begin
    res.dz = (d_r[DIV_STG-1] == '0);
    if (neg_r[DIV_STG-1]) begin
      res.sat = ovf_r[DIV_STG-1] || (q_fin > NEG_LIM);
      res.val = res.sat ? OUT_MIN : OUT_W'(-q_fin);
    end else begin
      res.sat = ovf_r[DIV_STG-1] || (q_fin > POS_LIM);
      res.val = res.sat ? OUT_MAX : q_fin[OUT_W-1:0];
    end
  end

endmodule
